/* rtl/stable_priority_task_queue_macros.svh */
// ----------------------------------------------------------------------------
// stable priority task queue assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_TASK_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_TASK_QUEUE_MACROS_SVH

// same-cycle implication
`define SPTQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sptq assertion failed");

// next-cycle implication
`define SPTQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sptq assertion failed");

`endif

/* rtl/sptq_pkg.sv */
// ----------------------------------------------------------------------------
// sptq_pkg
// sizes, result codes and action codes of the stable priority task queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sptq_pkg;

	localparam int QUEUE_DEPTH   = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int HANDLE_BITS   = 32;
	localparam int COUNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int STATUS_BITS   = 2;

	localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(QUEUE_DEPTH);

	// action codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// result status codes
	localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

/* rtl/stable_priority_task_queue.sv */
// ----------------------------------------------------------------------------
// stable_priority_task_queue
// bounded stable min-priority queue of task handles, sorted-insert shift array
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one command per transaction:
//   action selects push or pop, item_priority and item_handle matter for a
//   push only. lower priority values leave first, equal values leave in
//   arrival order.
//   output channel (out_valid / out_stall) returns exactly one result per
//   command: status, popped_handle and entry_count after the operation.
//   the result is registered, presented in the cycle after the command is taken.
//   throughput: one command per cycle while in_stall is low; every slot
//   compares against the new priority and shifts in parallel.
//   the single output register decouples the sides: a new command is taken
//   whenever that register is empty or is being emptied in the same cycle.
//   while the receiver stalls a waiting result, in_stall is raised and the
//   result holds steady.
//   reset (arst_n low) empties the queue and drops any pending result; the
//   slot contents are not cleared, only the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_task_queue (
	input  wire                                          clk,
	input  wire                                          arst_n,
	// command transactions
	input  wire                                          in_valid,
	output logic                                         in_stall,
	input  wire                                          action,
	input  wire  [sptq_pkg::PRIORITY_BITS-1:0]           item_priority,
	input  wire  [sptq_pkg::HANDLE_BITS-1:0]             item_handle,
	// result transactions
	output logic                                         out_valid,
	input  wire                                          out_stall,
	output logic [sptq_pkg::STATUS_BITS-1:0]             status,
	output logic [sptq_pkg::HANDLE_BITS-1:0]             popped_handle,
	output logic [sptq_pkg::COUNT_BITS-1:0]              entry_count
);

	localparam int D  = sptq_pkg::QUEUE_DEPTH;
	localparam int PB = sptq_pkg::PRIORITY_BITS;
	localparam int HB = sptq_pkg::HANDLE_BITS;
	localparam int CB = sptq_pkg::COUNT_BITS;
	localparam int SB = sptq_pkg::STATUS_BITS;

	// sorted slot array, slot 0 is the front
	logic [PB-1:0] prio_q   [D];
	logic [HB-1:0] handle_q [D];
	logic [PB-1:0] prio_nxt   [D];
	logic [HB-1:0] handle_nxt [D];
	logic [CB-1:0] count_q;

	// result register
	logic          out_valid_q;
	logic [SB-1:0] status_q;
	logic [HB-1:0] popped_q;
	logic [CB-1:0] count_out_q;

	logic          accept;
	logic          full;
	logic          empty;
	logic          do_push;
	logic          do_pop;
	logic [D-1:0]  le;      // slot holds an entry that stays ahead of the new one

	// the output register is free or drains this cycle
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign full    = (count_q == sptq_pkg::FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_push = (action == sptq_pkg::ACT_PUSH) & ~full;
	assign do_pop  = (action == sptq_pkg::ACT_POP) & ~empty;

	// per-slot compare and shift select
	for (genvar i = 0; i < D; i++) begin : g_slot
		localparam logic [CB-1:0] IDX = CB'(i);

		assign le[i] = (IDX < count_q) && (prio_q[i] <= item_priority);

		if (i == 0) begin : g_front
			always_comb begin
				prio_nxt[i]   = prio_q[i];
				handle_nxt[i] = handle_q[i];
				if (do_pop) begin
					prio_nxt[i]   = prio_q[i+1];
					handle_nxt[i] = handle_q[i+1];
				end else if (do_push && !le[i]) begin
					// new entry goes to the front
					prio_nxt[i]   = item_priority;
					handle_nxt[i] = item_handle;
				end
			end
		end else if (i == D - 1) begin : g_back
			always_comb begin
				prio_nxt[i]   = prio_q[i];
				handle_nxt[i] = handle_q[i];
				if (do_push && !le[i]) begin
					if (le[i-1]) begin
						prio_nxt[i]   = item_priority;
						handle_nxt[i] = item_handle;
					end else begin
						prio_nxt[i]   = prio_q[i-1];
						handle_nxt[i] = handle_q[i-1];
					end
				end
			end
		end else begin : g_mid
			always_comb begin
				prio_nxt[i]   = prio_q[i];
				handle_nxt[i] = handle_q[i];
				if (do_pop) begin
					prio_nxt[i]   = prio_q[i+1];
					handle_nxt[i] = handle_q[i+1];
				end else if (do_push && !le[i]) begin
					// first slot past the equal-or-lower run takes the new entry
					if (le[i-1]) begin
						prio_nxt[i]   = item_priority;
						handle_nxt[i] = item_handle;
					end else begin
						prio_nxt[i]   = prio_q[i-1];
						handle_nxt[i] = handle_q[i-1];
					end
				end
			end
		end
	end

	// slot storage, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < D; i++) begin
				prio_q[i]   <= prio_nxt[i];
				handle_q[i] <= handle_nxt[i];
			end
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (do_push) begin
				count_q <= count_q + CB'(1);
			end else if (do_pop) begin
				count_q <= count_q - CB'(1);
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (action == sptq_pkg::ACT_PUSH) begin
				popped_q <= '0;
				if (full) begin
					status_q    <= sptq_pkg::STATUS_FULL;
					count_out_q <= count_q;
				end else begin
					status_q    <= sptq_pkg::STATUS_OK;
					count_out_q <= count_q + CB'(1);
				end
			end else begin
				if (empty) begin
					status_q    <= sptq_pkg::STATUS_EMPTY;
					popped_q    <= '0;
					count_out_q <= count_q;
				end else begin
					status_q    <= sptq_pkg::STATUS_OK;
					popped_q    <= handle_q[0];
					count_out_q <= count_q - CB'(1);
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign popped_handle = popped_q;
	assign entry_count   = count_out_q;

endmodule

`default_nettype wire

/* rtl/sptq_checker.sv */
// ----------------------------------------------------------------------------
// sptq_checker
// port-level checks on the stable priority task queue, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stable_priority_task_queue_macros.svh"

module sptq_checker (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  in_valid,
	input wire                                  in_stall,
	input wire                                  out_valid,
	input wire                                  out_stall,
	input wire [sptq_pkg::STATUS_BITS-1:0]      status,
	input wire [sptq_pkg::HANDLE_BITS-1:0]      popped_handle,
	input wire [sptq_pkg::COUNT_BITS-1:0]       entry_count
);

	// a stalled result holds
	`SPTQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(popped_handle) && $stable(entry_count))

	// no transaction taken while a result is held back
	`SPTQ_ASSERT_NOW(a_backpressure, out_valid && out_stall, in_stall)

	// a dropped push only happens at full occupancy
	`SPTQ_ASSERT_NOW(a_full_count, out_valid && status == sptq_pkg::STATUS_FULL, entry_count == sptq_pkg::FULL_COUNT && popped_handle == '0)

	// an empty pop leaves the queue empty and returns zero
	`SPTQ_ASSERT_NOW(a_empty_pop, out_valid && status == sptq_pkg::STATUS_EMPTY, entry_count == '0 && popped_handle == '0)

	// an accepted command yields a result in the next cycle
	`SPTQ_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid)

endmodule

bind stable_priority_task_queue sptq_checker u_sptq_checker (.*);

`default_nettype wire
